FILE: sv/nfe2_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time functions for the note to frequency unit.
// Used by note_to_frequency_exp2_unit; depends on nothing else.
package nfe2_pkg;

    // Default size of the fractional exp2 table (entries per octave of the fraction).
    localparam int FRACTION_TABLE_ENTRIES_DEFAULT = 256;

    localparam int NOTE_W = 8;
    localparam int FREQ_W = 32;
    localparam int DIV_W = 16;
    localparam int QUOT_W = 32;
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES = QUOT_W / DIV_BITS_PER_STAGE;

    // Exponent limits that select the scaling mode.
    localparam int EXP_SHIFT_BASE = 14;
    localparam int EXP_HUGE_LIMIT = 16;

    localparam logic [DIV_W-1:0] OCTAVE_DIVISIONS_RESET = 16'd3072;
    localparam logic signed [FREQ_W-1:0] TUNE_OFFSET_RESET = 32'sd0;
    localparam logic signed [FREQ_W-1:0] FREQ_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [FREQ_W-1:0] FREQ_MIN = 32'sh8000_0000;

    localparam logic [63:0] LN2_Q30 = 64'd744261118;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    typedef enum logic [1:0] {
        CFG_OCTAVE_DIVISIONS = 2'd0,
        CFG_TUNE_OFFSET      = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic signed [NOTE_W-1:0] note_number;
        logic                     last_in;
    } note_item_t;

    typedef struct packed {
        logic signed [FREQ_W-1:0] frequency;
        logic                     saturated;
        logic                     last_out;
    } freq_item_t;

    // One slot of the divider pipeline: partial remainder, numerator bits still to
    // shift in at the top and quotient bits collected at the bottom.
    typedef struct packed {
        logic [DIV_W-1:0]  rem;
        logic [QUOT_W-1:0] nq;
        logic              neg;
        logic              last;
    } div_stage_t;

    // Shift-subtract division, evaluated only on constants during elaboration.
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int j = 63; j >= 0; j--) begin
            r = {r[62:0], a[j]};
            if (r >= b) begin
                r = r - b;
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry k of the table: 2^(k/n) in Q2.30 from a rounded Taylor series of exp(t*ln2).
    function automatic logic [63:0] exp_entry(input logic [63:0] k, input logic [63:0] n);
        logic [63:0] t;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        if (k >= n) begin
            return ONE_Q30 << 1;
        end
        t = udiv64((k << 30) + (n >> 1), n);
        y = (t * LN2_Q30 + (ONE_Q30 >> 1)) >> 30;
        term = ONE_Q30;
        sum = ONE_Q30;
        for (int j = 1; j <= 20; j++) begin
            term = (term * y + (ONE_Q30 >> 1)) >> 30;
            term = udiv64(term + (64'(j) >> 1), 64'(j));
            sum = sum + term;
        end
        return sum;
    endfunction

endpackage

FILE: sv/note_to_frequency_exp2_unit.sv
`timescale 1ns / 1ps
// Top level of the note to frequency unit: a 15-stage pipeline computing
// 2^(note / divisions) + offset in Q16.16. Depends on nfe2_pkg.
//
// Usage. Notes arrive on the note channel (note_valid, note_ready, note), one
// transfer per note, and results leave on the freq channel (freq_valid,
// freq_ready, freq) in the same order, one result per note, carrying the last
// marker along. Two registers sit behind the cfg channel: index 0 holds the
// steps per octave (unsigned Q8.8) and index 1 the tune offset (signed Q16.16);
// other indexes are ignored. cfg_ready is always high, and the registers may
// only be written while no note is in flight.
// Timing. The pipeline takes one note per cycle while it is not stalled. A note
// passes the entry register, the divider (eight stages of four quotient bits
// each), the exponent split, the table read, the two interpolation multipliers,
// the scaling shift and the output adder before its result shows on freq.
// Stalls. Every stage keeps a valid bit, and a stage advances whenever freq_ready
// is high or some stage at or after it is empty, so bubbles close up and
// note_ready stays high until all 15 stages hold notes and freq_ready is low.
// Nothing is dropped or duplicated while stalled.
// Reset. rst_n clears all valid bits and loads the reset values of the
// registers (12.0 steps per octave, zero offset); no clearing pass is needed.
module note_to_frequency_exp2_unit #(
    parameter int FRACTION_TABLE_ENTRIES = nfe2_pkg::FRACTION_TABLE_ENTRIES_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  nfe2_pkg::cfg_index_t   cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic                   note_valid,
    output logic                   note_ready,
    input  nfe2_pkg::note_item_t   note,
    output logic                   freq_valid,
    input  logic                   freq_ready,
    output nfe2_pkg::freq_item_t   freq
);

    localparam int IDX_W = $clog2(FRACTION_TABLE_ENTRIES + 1);
    localparam int P_W = 16 + IDX_W;
    localparam int DIV_STAGES = nfe2_pkg::DIV_STAGES;
    localparam int ST_EXP = DIV_STAGES + 1;
    localparam int ST_ROM = DIV_STAGES + 2;
    localparam int ST_MUL = DIV_STAGES + 3;
    localparam int ST_INTERP = DIV_STAGES + 4;
    localparam int ST_SHIFT = DIV_STAGES + 5;
    localparam int ST_OUT = DIV_STAGES + 6;
    localparam int NS = ST_OUT + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0]        octave_divisions_reg;
    logic signed [31:0] tune_offset_reg;
    logic [15:0]        div_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_divisions_reg <= nfe2_pkg::OCTAVE_DIVISIONS_RESET;
            tune_offset_reg      <= nfe2_pkg::TUNE_OFFSET_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                nfe2_pkg::CFG_OCTAVE_DIVISIONS: octave_divisions_reg <= cfg_data[15:0];
                nfe2_pkg::CFG_TUNE_OFFSET:      tune_offset_reg <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    // A divisor of zero behaves as the smallest nonzero divisor, one LSB.
    assign div_eff = (octave_divisions_reg == '0) ? 16'd1 : octave_divisions_reg;

    // ------------------------------------------------------------------
    // Valid bits and stage enables
    // ------------------------------------------------------------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] en;

    // A stage may load when any stage from it to the output is empty or the
    // output is being taken this cycle.
    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            en[k] = freq_ready || (|(~vld_reg & ({NS{1'b1}} << k)));
        end
        vld_next = (en & {vld_reg[NS-2:0], note_valid}) | (~en & vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign note_ready = en[0];
    assign freq_valid = vld_reg[ST_OUT];

    // ------------------------------------------------------------------
    // Entry stage and divider: q = ((|note| << 24) + div/2) / div
    // ------------------------------------------------------------------
    function automatic nfe2_pkg::div_stage_t div_step(input nfe2_pkg::div_stage_t s,
                                                      input logic [15:0] d);
        nfe2_pkg::div_stage_t o;
        logic [16:0] r2;
        o = s;
        for (int j = 0; j < nfe2_pkg::DIV_BITS_PER_STAGE; j++)
        begin
            r2 = {o.rem, o.nq[31]};
            if (r2 >= {1'b0, d})
            begin
                o.rem = 16'(r2 - {1'b0, d});
                o.nq  = {o.nq[30:0], 1'b1};
            end
            else
            begin
                o.rem = r2[15:0];
                o.nq  = {o.nq[30:0], 1'b0};
            end
        end
        return o;
    endfunction

    nfe2_pkg::div_stage_t div_reg [DIV_STAGES+1];
    nfe2_pkg::div_stage_t entry_next;
    logic [7:0]           note_mag;

    always_comb
    begin
        note_mag = note.note_number[7] ? 8'(8'd0 - note.note_number) : note.note_number;
        entry_next.rem  = '0;
        entry_next.nq   = {note_mag, 24'd0} + {17'd0, div_eff[15:1]};
        entry_next.neg  = note.note_number[7];
        entry_next.last = note.last_in;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            div_reg[0] <= entry_next;
        end
    end

    for (genvar gk = 1; gk <= DIV_STAGES; gk++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en[gk])
            begin
                div_reg[gk] <= div_step(div_reg[gk-1], div_eff);
            end
        end
    end

    // ------------------------------------------------------------------
    // Exponent split: integer part and table position
    // ------------------------------------------------------------------
    logic signed [32:0] x_val;
    logic [P_W-1:0]     p_val;
    logic signed [16:0] exp_i_reg;
    logic [IDX_W-1:0]   exp_idx_reg;
    logic [15:0]        exp_w_reg;
    logic               exp_last_reg;

    always_comb
    begin
        x_val = div_reg[DIV_STAGES].neg ? -signed'({1'b0, div_reg[DIV_STAGES].nq})
                                        : signed'({1'b0, div_reg[DIV_STAGES].nq});
        p_val = P_W'(x_val[15:0]) * P_W'(FRACTION_TABLE_ENTRIES);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_EXP])
        begin
            exp_i_reg    <= x_val[32:16];
            exp_idx_reg  <= p_val[16 +: IDX_W];
            exp_w_reg    <= p_val[15:0];
            exp_last_reg <= div_reg[DIV_STAGES].last;
        end
    end

    // ------------------------------------------------------------------
    // Fraction table read (constant table built at elaboration)
    // ------------------------------------------------------------------
    logic [31:0]        exp_table [FRACTION_TABLE_ENTRIES+1];
    logic [31:0]        rom_t0_reg;
    logic [31:0]        rom_t1_reg;
    logic [15:0]        rom_w_reg;
    logic signed [16:0] rom_i_reg;
    logic               rom_last_reg;

    for (genvar gt = 0; gt <= FRACTION_TABLE_ENTRIES; gt++)
    begin : g_table
        assign exp_table[gt] =
            32'(nfe2_pkg::exp_entry(64'(gt), 64'(FRACTION_TABLE_ENTRIES)));
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_ROM])
        begin
            rom_t0_reg   <= exp_table[exp_idx_reg];
            rom_t1_reg   <= exp_table[IDX_W'(exp_idx_reg + 1'b1)];
            rom_w_reg    <= exp_w_reg;
            rom_i_reg    <= exp_i_reg;
            rom_last_reg <= exp_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Interpolation products
    // ------------------------------------------------------------------
    logic [48:0]        mul_p0_reg;
    logic [47:0]        mul_p1_reg;
    logic signed [16:0] mul_i_reg;
    logic               mul_last_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
        begin
            mul_p0_reg   <= 49'(rom_t0_reg) * 49'(17'h1_0000 - {1'b0, rom_w_reg});
            mul_p1_reg   <= 48'(rom_t1_reg) * 48'(rom_w_reg);
            mul_i_reg    <= rom_i_reg;
            mul_last_reg <= rom_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Interpolated mantissa and scaling decision
    // ------------------------------------------------------------------
    logic [49:0]        msum;
    logic signed [17:0] rshift;
    logic               left_next;
    logic               huge_next;
    logic [5:0]         shamt_next;
    logic [31:0]        int_m_reg;
    logic [5:0]         int_shamt_reg;
    logic               int_left_reg;
    logic               int_huge_reg;
    logic               int_last_reg;

    always_comb
    begin
        msum = 50'(mul_p0_reg) + 50'(mul_p1_reg) + 50'd32768;
        huge_next = mul_i_reg > 17'(nfe2_pkg::EXP_HUGE_LIMIT);
        left_next = mul_i_reg >= 17'(nfe2_pkg::EXP_SHIFT_BASE);
        // Right shifts are done one short, the last bit goes into rounding.
        rshift = 18'(nfe2_pkg::EXP_SHIFT_BASE - 1) - 18'(mul_i_reg);
        if (left_next)
        begin
            shamt_next = 6'(mul_i_reg - 17'(nfe2_pkg::EXP_SHIFT_BASE));
        end
        else if (rshift > 18'sd63)
        begin
            shamt_next = 6'd63;
        end
        else
        begin
            shamt_next = rshift[5:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_INTERP])
        begin
            int_m_reg     <= msum[47:16];
            int_shamt_reg <= shamt_next;
            int_left_reg  <= left_next;
            int_huge_reg  <= huge_next;
            int_last_reg  <= mul_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Power-of-two scaling
    // ------------------------------------------------------------------
    logic [33:0] sh_val_reg;
    logic        sh_left_reg;
    logic        sh_huge_reg;
    logic        sh_last_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_SHIFT])
        begin
            sh_val_reg  <= int_left_reg ? (34'(int_m_reg) << int_shamt_reg)
                                        : (34'(int_m_reg) >> int_shamt_reg);
            sh_left_reg <= int_left_reg;
            sh_huge_reg <= int_huge_reg;
            sh_last_reg <= int_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Rounding, offset and clamp into the output register
    // ------------------------------------------------------------------
    logic [33:0]          v_val;
    logic signed [35:0]   sum_val;
    nfe2_pkg::freq_item_t freq_next;
    nfe2_pkg::freq_item_t freq_reg;

    always_comb
    begin
        v_val = sh_left_reg ? sh_val_reg : ((sh_val_reg + 34'd1) >> 1);
        sum_val = signed'({2'b00, v_val}) + 36'(tune_offset_reg);
        freq_next.last_out = sh_last_reg;
        if (sh_huge_reg)
        begin
            freq_next.frequency = nfe2_pkg::FREQ_MAX;
            freq_next.saturated = 1'b1;
        end
        else if (sum_val > 36'(nfe2_pkg::FREQ_MAX))
        begin
            freq_next.frequency = nfe2_pkg::FREQ_MAX;
            freq_next.saturated = 1'b1;
        end
        else if (sum_val < 36'(nfe2_pkg::FREQ_MIN))
        begin
            freq_next.frequency = nfe2_pkg::FREQ_MIN;
            freq_next.saturated = 1'b1;
        end
        else
        begin
            freq_next.frequency = sum_val[31:0];
            freq_next.saturated = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            freq_reg <= freq_next;
        end
    end

    assign freq = freq_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An empty output register must never block new notes.
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[ST_OUT] |-> note_ready)
        else $error("note_ready low although the output stage is empty");

    // An accepted note always lands in the entry stage.
    a_entry_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        note_valid && note_ready |=> vld_reg[0])
        else $error("accepted note missing from the entry stage");

    // A held middle stage keeps both its valid bit and its table position.
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_EXP] && !en[ST_EXP] |=> vld_reg[ST_EXP] && $stable(exp_idx_reg))
        else $error("stalled exponent stage lost its item");

    // A clamped result is one of the two range limits.
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        freq_valid && freq.saturated |->
            freq.frequency == nfe2_pkg::FREQ_MAX || freq.frequency == nfe2_pkg::FREQ_MIN)
        else $error("saturated flag set on a value inside the range");

endmodule
